@@ hw/rtl/tpmd_pkg.sv @@
// Shared widths, types and constants of the tangent-plane move direction pipeline.
package tpmd_pkg;

  localparam int FRAC_BITS  = 14;               // vector fraction bits
  localparam int STICK_FRAC = 15;               // stick fraction bits
  localparam int COMP_W     = 16;               // port vector component width
  localparam int VW         = 21;               // unnormalized vector component width
  localparam int MAG_W      = 20;               // magnitude of an unnormalized component
  localparam int SUM_W      = 40;               // sum of three squares
  localparam int LEN_W      = SUM_W / 2;        // floor square root
  localparam int SQ_STEPS   = SUM_W / 2;        // one root bit per stage
  localparam int REM_W      = LEN_W + 4;        // square root remainder
  localparam int Q_W        = FRAC_BITS + 1;    // quotient magnitude, at most one
  localparam int DIV_STEPS  = Q_W;              // one quotient bit per stage
  localparam int DVD_W      = MAG_W + FRAC_BITS + 1;
  localparam int NORM_LAT   = 2 + SQ_STEPS + 1 + DIV_STEPS;
  localparam int EPS_W      = 15;
  localparam logic [EPS_W-1:0] EPS_RESET = 15'd16;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [VW-1:0]     wide_t;
  typedef logic [LEN_W-1:0]         len_t;

  localparam comp_t ONE = comp_t'(1 << FRAC_BITS);

endpackage

@@ hw/rtl/tpmd_norm.sv @@
// Pipelined vector length (floor square root) and per-component normalize divider.
module tpmd_norm (
  input  logic             clk,
  input  logic             advance,
  input  tpmd_pkg::wide_t  vec [3],
  output tpmd_pkg::len_t   len,
  output tpmd_pkg::comp_t  q [3]
);

  logic signed [2*tpmd_pkg::VW-1:0] a_sq [3];
  tpmd_pkg::wide_t                  a_vec [3];

  logic [tpmd_pkg::SUM_W-1:0] rad  [0:tpmd_pkg::SQ_STEPS];
  logic [tpmd_pkg::REM_W-1:0] rem  [0:tpmd_pkg::SQ_STEPS];
  tpmd_pkg::len_t             root [0:tpmd_pkg::SQ_STEPS];
  tpmd_pkg::wide_t            vp   [0:tpmd_pkg::SQ_STEPS][3];

  logic [tpmd_pkg::DVD_W-1:0] dvd  [0:tpmd_pkg::DIV_STEPS][3];
  logic [tpmd_pkg::Q_W-1:0]   quo  [0:tpmd_pkg::DIV_STEPS][3];
  logic [2:0]                 dneg [0:tpmd_pkg::DIV_STEPS];
  tpmd_pkg::len_t             dlen [0:tpmd_pkg::DIV_STEPS];

  tpmd_pkg::wide_t            absv [3];
  logic [tpmd_pkg::DVD_W-1:0] dvd0 [3];

  // squares, then their sum
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int c = 0; c < 3; c++) begin
        a_sq[c]  <= vec[c] * vec[c];
        a_vec[c] <= vec[c];
      end
      rad[0]  <= a_sq[0][tpmd_pkg::SUM_W-1:0] + a_sq[1][tpmd_pkg::SUM_W-1:0]
               + a_sq[2][tpmd_pkg::SUM_W-1:0];
      rem[0]  <= '0;
      root[0] <= '0;
      vp[0]   <= a_vec;
    end
  end

  // digit-by-digit square root, two radicand bits per stage
  for (genvar i = 0; i < tpmd_pkg::SQ_STEPS; i++) begin : g_sqrt
    logic [tpmd_pkg::REM_W-1:0] rem_sh;
    logic [tpmd_pkg::REM_W-1:0] trial;
    logic                       fits;

    assign rem_sh = {rem[i][tpmd_pkg::REM_W-3:0], rad[i][tpmd_pkg::SUM_W-1 -: 2]};
    assign trial  = {{(tpmd_pkg::REM_W-tpmd_pkg::LEN_W-2){1'b0}}, root[i], 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (advance) begin
        rad[i+1]  <= rad[i] << 2;
        rem[i+1]  <= fits ? rem_sh - trial : rem_sh;
        root[i+1] <= {root[i][tpmd_pkg::LEN_W-2:0], fits};
        vp[i+1]   <= vp[i];
      end
    end
  end

  // dividend: |component| scaled up, plus half the length for rounding
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      absv[c] = vp[tpmd_pkg::SQ_STEPS][c][tpmd_pkg::VW-1] ? -vp[tpmd_pkg::SQ_STEPS][c]
                                                          : vp[tpmd_pkg::SQ_STEPS][c];
      dvd0[c] = ({{(tpmd_pkg::DVD_W-tpmd_pkg::MAG_W){1'b0}}, absv[c][tpmd_pkg::MAG_W-1:0]}
                 << tpmd_pkg::FRAC_BITS)
              + {{(tpmd_pkg::DVD_W-tpmd_pkg::LEN_W){1'b0}}, root[tpmd_pkg::SQ_STEPS] >> 1};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int c = 0; c < 3; c++) begin
        dvd[0][c]  <= dvd0[c];
        quo[0][c]  <= '0;
        dneg[0][c] <= vp[tpmd_pkg::SQ_STEPS][c][tpmd_pkg::VW-1];
      end
      dlen[0] <= root[tpmd_pkg::SQ_STEPS];
    end
  end

  // restoring division, one quotient bit per stage, most significant first
  for (genvar j = 0; j < tpmd_pkg::DIV_STEPS; j++) begin : g_div
    logic [tpmd_pkg::DVD_W-1:0] sub;
    logic [2:0]                 fits;

    assign sub = {{(tpmd_pkg::DVD_W-tpmd_pkg::LEN_W){1'b0}}, dlen[j]}
                 << (tpmd_pkg::DIV_STEPS - 1 - j);

    always_comb begin
      for (int c = 0; c < 3; c++) fits[c] = dvd[j][c] >= sub;
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        for (int c = 0; c < 3; c++) begin
          dvd[j+1][c] <= fits[c] ? dvd[j][c] - sub : dvd[j][c];
          quo[j+1][c] <= {quo[j][c][tpmd_pkg::Q_W-2:0], fits[c]};
        end
        dneg[j+1] <= dneg[j];
        dlen[j+1] <= dlen[j];
      end
    end
  end

  assign len = dlen[tpmd_pkg::DIV_STEPS];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q[c] = dneg[tpmd_pkg::DIV_STEPS][c]
           ? -tpmd_pkg::comp_t'({1'b0, quo[tpmd_pkg::DIV_STEPS][c]})
           :  tpmd_pkg::comp_t'({1'b0, quo[tpmd_pkg::DIV_STEPS][c]});
    end
  end

endmodule

@@ hw/rtl/tangent_plane_move_direction.sv @@
// Top level: stick input to unit move direction in the surface tangent plane.
//
// Channels: the slave stream takes one request per beat: the stick pair, the
// surface normal, camera forward and right, and in tuser the world-axes flag.
// The master stream returns one beat per request: the direction in tdata and
// in tuser a flag that is 1 for a nonzero direction (the vector is all zero
// when the flag is 0).
// cfg_wr_en / cfg_wr_data load the length epsilon; write it only while idle.
// Throughput: one request per clock unless stalled; each stage is a register
// and the pipe advances as a whole, so a beat can follow in the next cycle.
// Pipeline, from acceptance to output valid: a 5-stage projection front end,
// three 38-stage length/normalize units (root: one bit per stage, divider:
// one quotient bit per stage) in series, 3-stage cross product and 3-stage
// stick mix between them, and the output register.
// Reset clears every valid bit and loads the epsilon with 16.
// Stall: while the output holds a beat the receiver has not taken, the pipe
// freezes and s_axis_tready drops; nothing is lost or repeated.
module tangent_plane_move_direction (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // stick_x, stick_z, normal_x, normal_y, normal_z, fwd_x, fwd_y, fwd_z,
  // right_x, right_y, right_z
  input  logic [175:0] s_axis_tdata,
  // use_world_axes
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // dir_x, dir_y, dir_z
  output logic [47:0]  m_axis_tdata,
  // dir_valid
  output logic         m_axis_tuser,
  input  logic         cfg_wr_en,
  input  logic [14:0]  cfg_wr_data
);

  typedef logic signed [31:0] prod_t;
  typedef logic signed [33:0] dot_t;
  typedef logic signed [19:0] dpr_t;
  typedef logic signed [35:0] nprod_t;

  typedef struct packed {
    tpmd_pkg::comp_t        sx;
    tpmd_pkg::comp_t        sz;
    tpmd_pkg::comp_t [2:0]  n;
    logic                   snz;
  } side1_t;

  typedef struct packed {
    tpmd_pkg::comp_t        sx;
    tpmd_pkg::comp_t        sz;
    tpmd_pkg::comp_t [2:0]  f;
    tpmd_pkg::comp_t [2:0]  r;
    logic                   rok;
    logic                   go;
  } side2_t;

  // round half away from zero on a right shift
  function automatic logic signed [39:0] rsr(input logic signed [39:0] x,
                                             input int unsigned s);
    logic [39:0] m;
    logic [39:0] r;
    m = x[39] ? 40'(-x) : 40'(x);
    r = (m + (40'd1 << (s - 1))) >> s;
    return x[39] ? -$signed(r) : $signed(r);
  endfunction

  logic                           advance;
  logic [tpmd_pkg::EPS_W-1:0]     length_epsilon;
  tpmd_pkg::len_t                 eps_len;

  // stage 1: capture, world-axes substitution
  logic            s1_valid;
  tpmd_pkg::comp_t s1_sx, s1_sz;
  tpmd_pkg::comp_t s1_n [3], s1_fv [3], s1_rv [3];
  logic            s1_snz;
  // stage 2: normal times vector
  logic            s2_valid;
  side1_t          s2_side;
  tpmd_pkg::comp_t s2_fv [3], s2_rv [3];
  prod_t           s2_pf [3], s2_pr [3];
  // stage 3: dot products
  logic            s3_valid;
  side1_t          s3_side;
  tpmd_pkg::comp_t s3_fv [3], s3_rv [3];
  dpr_t            s3_df, s3_dr;
  dot_t            dot_f, dot_r;
  // stage 4: normal scaled by dot
  logic            s4_valid;
  side1_t          s4_side;
  tpmd_pkg::comp_t s4_fv [3], s4_rv [3];
  nprod_t          s4_pnf [3], s4_pnr [3];
  // stage 5: projected vectors
  logic            s5_valid;
  side1_t          s5_side;
  tpmd_pkg::wide_t s5_tf [3], s5_tr [3];

  side1_t                        dl1 [tpmd_pkg::NORM_LAT];
  logic [tpmd_pkg::NORM_LAT-1:0] dv1;
  tpmd_pkg::len_t                nf_len, nr_len;
  tpmd_pkg::comp_t               nf_q [3], nr_q [3];
  logic                          fok, rok;

  // stage 6: pick forward
  logic            s6_valid;
  side1_t          s6_side;
  tpmd_pkg::comp_t s6_f [3], s6_r [3];
  logic            s6_rok, s6_go;
  // stage 7: cross products
  logic            s7_valid;
  side2_t          s7_side;
  prod_t           s7_cp [6];
  // stage 8: rebuilt right, unnormalized
  logic            s8_valid;
  side2_t          s8_side;
  tpmd_pkg::wide_t s8_c [3];

  side2_t                        dl2 [tpmd_pkg::NORM_LAT];
  logic [tpmd_pkg::NORM_LAT-1:0] dv2;
  tpmd_pkg::len_t                nc_len;
  tpmd_pkg::comp_t               nc_q [3];
  side2_t                        c_side;

  // stage 9: pick right
  logic            s9_valid;
  tpmd_pkg::comp_t s9_sx, s9_sz;
  tpmd_pkg::comp_t s9_f [3], s9_r [3];
  logic            s9_go;
  // stage 10: stick weights
  logic            s10_valid;
  logic            s10_go;
  prod_t           s10_pf [3], s10_pr [3];
  // stage 11: weighted sum
  logic            s11_valid;
  logic            s11_go;
  tpmd_pkg::wide_t s11_m [3];

  logic [tpmd_pkg::NORM_LAT-1:0] dv3, dl3_go;
  tpmd_pkg::len_t                nm_len;
  tpmd_pkg::comp_t               nm_q [3];
  logic                          dir_ok;

  // the pipe moves whenever the output register is free or being drained
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign eps_len       = tpmd_pkg::len_t'(length_epsilon);

  always_ff @(posedge clk) begin
    if (rst) begin
      length_epsilon <= tpmd_pkg::EPS_RESET;
    end else if (cfg_wr_en) begin
      length_epsilon <= cfg_wr_data;
    end
  end

  // valid bits travel with their requests
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      s4_valid      <= 1'b0;
      s5_valid      <= 1'b0;
      dv1           <= '0;
      s6_valid      <= 1'b0;
      s7_valid      <= 1'b0;
      s8_valid      <= 1'b0;
      dv2           <= '0;
      s9_valid      <= 1'b0;
      s10_valid     <= 1'b0;
      s11_valid     <= 1'b0;
      dv3           <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      s1_valid      <= s_axis_tvalid;
      s2_valid      <= s1_valid;
      s3_valid      <= s2_valid;
      s4_valid      <= s3_valid;
      s5_valid      <= s4_valid;
      dv1           <= {dv1[tpmd_pkg::NORM_LAT-2:0], s5_valid};
      s6_valid      <= dv1[tpmd_pkg::NORM_LAT-1];
      s7_valid      <= s6_valid;
      s8_valid      <= s7_valid;
      dv2           <= {dv2[tpmd_pkg::NORM_LAT-2:0], s8_valid};
      s9_valid      <= dv2[tpmd_pkg::NORM_LAT-1];
      s10_valid     <= s9_valid;
      s11_valid     <= s10_valid;
      dv3           <= {dv3[tpmd_pkg::NORM_LAT-2:0], s11_valid};
      m_axis_tvalid <= dv3[tpmd_pkg::NORM_LAT-1];
    end
  end

  // ---- front end: project forward and right onto the tangent plane ----
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sx  <= tpmd_pkg::comp_t'(s_axis_tdata[15:0]);
      s1_sz  <= tpmd_pkg::comp_t'(s_axis_tdata[31:16]);
      s1_snz <= s_axis_tdata[31:0] != '0;
      for (int i = 0; i < 3; i++) begin
        s1_n[i] <= tpmd_pkg::comp_t'(s_axis_tdata[32 + 16*i +: 16]);
        if (s_axis_tuser) begin
          s1_fv[i] <= (i == 2) ? tpmd_pkg::ONE : '0;
          s1_rv[i] <= (i == 0) ? tpmd_pkg::ONE : '0;
        end else begin
          s1_fv[i] <= tpmd_pkg::comp_t'(s_axis_tdata[80 + 16*i +: 16]);
          s1_rv[i] <= tpmd_pkg::comp_t'(s_axis_tdata[128 + 16*i +: 16]);
        end
      end
    end
  end

  always_comb begin
    dot_f = dot_t'(s2_pf[0]) + dot_t'(s2_pf[1]) + dot_t'(s2_pf[2]);
    dot_r = dot_t'(s2_pr[0]) + dot_t'(s2_pr[1]) + dot_t'(s2_pr[2]);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_side.sx  <= s1_sx;
      s2_side.sz  <= s1_sz;
      s2_side.snz <= s1_snz;
      for (int i = 0; i < 3; i++) begin
        s2_side.n[i] <= s1_n[i];
        s2_pf[i]     <= s1_n[i] * s1_fv[i];
        s2_pr[i]     <= s1_n[i] * s1_rv[i];
      end
      s2_fv <= s1_fv;
      s2_rv <= s1_rv;

      s3_side <= s2_side;
      s3_fv   <= s2_fv;
      s3_rv   <= s2_rv;
      s3_df   <= dpr_t'(rsr(40'(dot_f), tpmd_pkg::FRAC_BITS));
      s3_dr   <= dpr_t'(rsr(40'(dot_r), tpmd_pkg::FRAC_BITS));

      s4_side <= s3_side;
      s4_fv   <= s3_fv;
      s4_rv   <= s3_rv;
      for (int i = 0; i < 3; i++) begin
        s4_pnf[i] <= $signed(s3_side.n[i]) * s3_df;
        s4_pnr[i] <= $signed(s3_side.n[i]) * s3_dr;
      end

      s5_side <= s4_side;
      for (int i = 0; i < 3; i++) begin
        s5_tf[i] <= tpmd_pkg::wide_t'(s4_fv[i])
                  - tpmd_pkg::wide_t'(rsr(40'(s4_pnf[i]), tpmd_pkg::FRAC_BITS));
        s5_tr[i] <= tpmd_pkg::wide_t'(s4_rv[i])
                  - tpmd_pkg::wide_t'(rsr(40'(s4_pnr[i]), tpmd_pkg::FRAC_BITS));
      end
    end
  end

  tpmd_norm u_norm_fwd (
    .clk     (clk),
    .advance (advance),
    .vec     (s5_tf),
    .len     (nf_len),
    .q       (nf_q)
  );

  tpmd_norm u_norm_right (
    .clk     (clk),
    .advance (advance),
    .vec     (s5_tr),
    .len     (nr_len),
    .q       (nr_q)
  );

  // hold the side data alongside the two normalize units
  always_ff @(posedge clk) begin
    if (advance) begin
      dl1[0] <= s5_side;
      for (int i = 1; i < tpmd_pkg::NORM_LAT; i++) dl1[i] <= dl1[i-1];
    end
  end

  assign fok = nf_len > eps_len;
  assign rok = nr_len > eps_len;

  // ---- rebuild right from normal x forward when right degenerates ----
  always_ff @(posedge clk) begin
    if (advance) begin
      s6_side <= dl1[tpmd_pkg::NORM_LAT-1];
      for (int i = 0; i < 3; i++) begin
        s6_f[i] <= fok ? nf_q[i] : nr_q[i];   // fall back to right when forward degenerates
        s6_r[i] <= nr_q[i];
      end
      s6_rok  <= rok;
      s6_go   <= dl1[tpmd_pkg::NORM_LAT-1].snz && (fok || rok);

      s7_side.sx  <= s6_side.sx;
      s7_side.sz  <= s6_side.sz;
      s7_side.rok <= s6_rok;
      s7_side.go  <= s6_go;
      for (int i = 0; i < 3; i++) begin
        s7_side.f[i] <= s6_f[i];
        s7_side.r[i] <= s6_r[i];
      end
      s7_cp[0] <= $signed(s6_side.n[1]) * s6_f[2];
      s7_cp[1] <= $signed(s6_side.n[2]) * s6_f[1];
      s7_cp[2] <= $signed(s6_side.n[2]) * s6_f[0];
      s7_cp[3] <= $signed(s6_side.n[0]) * s6_f[2];
      s7_cp[4] <= $signed(s6_side.n[0]) * s6_f[1];
      s7_cp[5] <= $signed(s6_side.n[1]) * s6_f[0];

      s8_side <= s7_side;
      for (int i = 0; i < 3; i++) begin
        s8_c[i] <= tpmd_pkg::wide_t'(rsr(40'(s7_cp[2*i]) - 40'(s7_cp[2*i+1]),
                                         tpmd_pkg::FRAC_BITS));
      end
    end
  end

  tpmd_norm u_norm_cross (
    .clk     (clk),
    .advance (advance),
    .vec     (s8_c),
    .len     (nc_len),
    .q       (nc_q)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      dl2[0] <= s8_side;
      for (int i = 1; i < tpmd_pkg::NORM_LAT; i++) dl2[i] <= dl2[i-1];
    end
  end

  assign c_side = dl2[tpmd_pkg::NORM_LAT-1];

  // ---- stick-weighted sum ----
  always_ff @(posedge clk) begin
    if (advance) begin
      s9_sx <= c_side.sx;
      s9_sz <= c_side.sz;
      s9_go <= c_side.go;
      for (int i = 0; i < 3; i++) begin
        s9_f[i] <= c_side.f[i];
        // a rebuilt right of zero length drops to the zero vector
        if (c_side.rok) begin
          s9_r[i] <= c_side.r[i];
        end else if (nc_len != '0) begin
          s9_r[i] <= nc_q[i];
        end else begin
          s9_r[i] <= '0;
        end
      end

      s10_go <= s9_go;
      for (int i = 0; i < 3; i++) begin
        s10_pf[i] <= s9_f[i] * s9_sz;
        s10_pr[i] <= s9_r[i] * s9_sx;
      end

      s11_go <= s10_go;
      for (int i = 0; i < 3; i++) begin
        s11_m[i] <= tpmd_pkg::wide_t'(rsr(40'(s10_pf[i]) + 40'(s10_pr[i]),
                                          tpmd_pkg::STICK_FRAC));
      end
    end
  end

  tpmd_norm u_norm_move (
    .clk     (clk),
    .advance (advance),
    .vec     (s11_m),
    .len     (nm_len),
    .q       (nm_q)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      dl3_go <= {dl3_go[tpmd_pkg::NORM_LAT-2:0], s11_go};
    end
  end

  assign dir_ok = dl3_go[tpmd_pkg::NORM_LAT-1] && (nm_len > eps_len);

  // output register; drop to the zero vector when no direction was found
  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= dir_ok ? {nm_q[2], nm_q[1], nm_q[0]} : '0;
      m_axis_tuser <= dir_ok;
    end
  end

endmodule

@@ sim/tb.sv @@
// Testbench for the tangent-plane move direction block: directed and random requests.
`timescale 1ns / 100ps

module tb;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_wr_en;
  logic [14:0]  cfg_wr_data;

  // One request: tdata fields from the lowest bit up, plus the world-axes flag.
  typedef struct packed {
    logic         world;
    logic [175:0] data;
  } move_req_t;

  typedef struct packed {
    logic [47:0] dir;
    logic        ok;
  } move_dir_t;

  move_req_t pending_reqs[$];
  move_dir_t expected_dirs[$];
  logic [14:0] eps_model;
  int unsigned errors;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  tangent_plane_move_direction i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shift right, rounding half away from zero.
  function automatic longint round_shift(longint x, int s);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (x < 0) ? -m : m;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vec_len(longint v[3]);
    longint unsigned s;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(v[i] * v[i]);
    return floor_sqrt(s);
  endfunction

  function automatic void to_unit(longint v[3], longint len, output longint o[3]);
    longint m;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? -v[i] : v[i];
      m = ((m <<< tpmd_pkg::FRAC_BITS) + len / 2) / len;
      o[i] = (v[i] < 0) ? -m : m;
    end
  endfunction

  // Remove the normal component, then normalize; 0 when the rest is too short.
  function automatic bit flatten(longint n[3], longint v[3], output longint o[3]);
    longint lim, d, t[3], len;
    lim = 64'sd1 <<< 30;
    d = round_shift(n[0] * v[0] + n[1] * v[1] + n[2] * v[2], tpmd_pkg::FRAC_BITS);
    for (int i = 0; i < 3; i++)
      t[i] = clamp(v[i] - round_shift(n[i] * d, tpmd_pkg::FRAC_BITS), -lim, lim);
    len = vec_len(t);
    o = '{0, 0, 0};
    if (len > longint'(eps_model)) begin
      to_unit(t, len, o);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic move_dir_t predict_dir(move_req_t q);
    longint lim, sx, sz, n[3], fv[3], rv[3], f[3], r[3], c[3], m[3], d[3], len;
    bit fok, rok, ok;
    move_dir_t res;
    lim = 64'sd1 <<< 30;
    sx = longint'($signed(q.data[15:0]));
    sz = longint'($signed(q.data[31:16]));
    for (int i = 0; i < 3; i++) begin
      n[i]  = longint'($signed(q.data[32 + 16*i +: 16]));
      fv[i] = longint'($signed(q.data[80 + 16*i +: 16]));
      rv[i] = longint'($signed(q.data[128 + 16*i +: 16]));
    end
    if (q.world) begin
      fv = '{0, 0, 64'sd1 <<< tpmd_pkg::FRAC_BITS};
      rv = '{64'sd1 <<< tpmd_pkg::FRAC_BITS, 0, 0};
    end
    d = '{0, 0, 0};
    ok = 1'b0;
    if (sx != 0 || sz != 0) begin
      fok = flatten(n, fv, f);
      rok = flatten(n, rv, r);
      if (!fok && rok) f = r;
      if (fok || rok) begin
        // Rebuild a lost right vector as normal x forward.
        if (!rok) begin
          c[0] = clamp(round_shift(n[1]*f[2] - n[2]*f[1], tpmd_pkg::FRAC_BITS), -lim, lim);
          c[1] = clamp(round_shift(n[2]*f[0] - n[0]*f[2], tpmd_pkg::FRAC_BITS), -lim, lim);
          c[2] = clamp(round_shift(n[0]*f[1] - n[1]*f[0], tpmd_pkg::FRAC_BITS), -lim, lim);
          len = vec_len(c);
          r = '{0, 0, 0};
          if (len != 0) to_unit(c, len, r);
        end
        for (int i = 0; i < 3; i++)
          m[i] = clamp(round_shift(f[i] * sz + r[i] * sx, tpmd_pkg::STICK_FRAC),
                       -lim, lim);
        len = vec_len(m);
        if (len > longint'(eps_model)) begin
          to_unit(m, len, d);
          ok = 1'b1;
        end
      end
    end
    for (int i = 0; i < 3; i++) res.dir[16*i +: 16] = 16'(clamp(d[i], -32768, 32767));
    res.ok = ok;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("%0t ERROR %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // Driver: hold a request until accepted, then advance to the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        move_req_t q;
        q = pending_reqs.pop_front();
        expected_dirs.push_back(predict_dir(q));
        s_axis_tdata  <= q.data;
        s_axis_tuser  <= q.world;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst) begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_dirs.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, '0);
        end else begin
          move_dir_t e;
          e = expected_dirs.pop_front();
          for (int i = 0; i < 3; i++)
            if (m_axis_tdata[16*i +: 16] !== e.dir[16*i +: 16])
              report_mismatch($sformatf("dir component %0d", i),
                              48'(m_axis_tdata[16*i +: 16]), 48'(e.dir[16*i +: 16]));
          if (m_axis_tuser !== e.ok)
            report_mismatch("dir_valid", 48'(m_axis_tuser), 48'(e.ok));
        end
      end
    end
  end

  function automatic logic [15:0] rnd_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(32768)) - 16384);
      default: return 16'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  // Unit-ish normal along a random axis with small tilt, or fully random.
  task automatic queue_random(int count);
    move_req_t q;
    int mode, ax;
    repeat (count) begin
      mode = $urandom_range(9);
      for (int i = 0; i < 11; i++) q.data[16*i +: 16] = rnd_comp(mode < 2 ? 0 : 1);
      if (mode >= 2) begin
        ax = $urandom_range(2);
        for (int i = 0; i < 3; i++) q.data[32 + 16*i +: 16] = rnd_comp(2);
        q.data[32 + 16*ax +: 16] = ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
      end
      if (mode == 9) q.data[31:0] = ($urandom_range(1)) ? 32'd0 : {16'd0, 16'($urandom)};
      if (mode == 8) q.data[175:80] = {q.data[79:32], q.data[79:32]};
      q.world = $urandom_range(1);
      pending_reqs.push_back(q);
    end
  endtask

  task automatic queue_req(logic [15:0] sx, logic [15:0] sz, logic [47:0] n,
                           logic [47:0] f, logic [47:0] r, logic w);
    move_req_t q;
    q.data  = {r, f, n, sz, sx};
    q.world = w;
    pending_reqs.push_back(q);
  endtask

  // Wait for the pipe to drain before touching the epsilon register.
  task automatic drain_and_set(logic [14:0] eps);
    while (pending_reqs.size() != 0 || expected_dirs.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= eps;
    eps_model   = eps;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  localparam logic [47:0] N_UP = {16'sd0, 16'sd16384, 16'sd0};
  localparam logic [47:0] V_Z  = {16'sd16384, 16'sd0, 16'sd0};
  localparam logic [47:0] V_X  = {16'sd0, 16'sd0, 16'sd16384};

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    eps_model     = tpmd_pkg::EPS_RESET;
    errors        = 0;
    send_idle_pct = 30;
    recv_idle_pct = 46;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero stick, extremes, world axes, degenerate forward/right.
    queue_req(16'd0, 16'd0, N_UP, V_Z, V_X, 1'b0);
    queue_req(16'h7FFF, 16'h7FFF, N_UP, V_Z, V_X, 1'b0);
    queue_req(16'h8000, 16'h8000, N_UP, V_Z, V_X, 1'b0);
    queue_req(16'h8000, 16'h7FFF, N_UP, '0, '0, 1'b1);
    queue_req(16'h1234, 16'h0000, V_Z, V_Z, V_X, 1'b0);   // forward along normal
    queue_req(16'h0000, 16'h4000, V_X, V_Z, V_X, 1'b0);   // right along normal
    queue_req(16'h4000, 16'h4000, V_Z, V_Z, V_Z, 1'b0);   // both lost
    queue_req(16'h4000, 16'h4000, '0, '0, '0, 1'b0);      // all zero vectors
    queue_req(16'hFFFF, 16'h0001, N_UP, V_Z, V_X, 1'b0);
    queue_req(16'h7FFF, 16'h8000, {3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}}, 1'b0);
    queue_req(16'h8000, 16'h7FFF, {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}, 1'b0);
    queue_req(16'hFFFF, 16'hFFFF, {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}}, 1'b1);
    queue_req(16'h2000, 16'h2000, V_X, V_X, V_Z, 1'b1);   // world forward kept
    queue_req(16'h2000, 16'h2000, V_Z, V_X, V_Z, 1'b1);   // world forward lost
    queue_random(80);

    drain_and_set(15'd0);
    queue_req(16'h0001, 16'h0000, N_UP, V_Z, V_X, 1'b0);
    queue_random(300);
    drain_and_set(15'h7FFF);
    queue_random(60);
    drain_and_set(15'd16384);
    queue_random(60);
    drain_and_set(15'd200);
    queue_random(250);

    send_idle_pct = 46;
    recv_idle_pct = 30;
    queue_random(450);
    drain_and_set(15'd16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(450);

    while (pending_reqs.size() != 0 || expected_dirs.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (errors == 0) begin
      $display("tangent_plane_move_direction: match");
    end else begin
      $display("tangent_plane_move_direction: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tangent_plane_move_direction: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tpmd_pkg.sv
hw/rtl/tpmd_norm.sv
hw/rtl/tangent_plane_move_direction.sv
sim/tb.sv
